FILE: hdl/ghi_pkg.sv
// package for the generalized hilbert index to xy core
// holds widths, the state encoding, the walk state record and small helper functions
// no dependencies
package ghi_pkg;

  localparam int DIM_BITS = 12;
  localparam int MAG_W    = DIM_BITS + 1;
  localparam int VEC_W    = DIM_BITS + 2;
  localparam int IDX_W    = 24;
  localparam int REG_W    = 13;
  localparam int AREA_W   = 2 * MAG_W;
  localparam int N_CELLS  = 4;

  localparam logic [MAG_W-1:0] DIM_MAX = MAG_W'(1) << DIM_BITS;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic signed [VEC_W-1:0] ax;
    logic signed [VEC_W-1:0] ay;
    logic signed [VEC_W-1:0] bx;
    logic signed [VEC_W-1:0] by;
    logic [IDX_W-1:0]        rem;
    logic [DIM_BITS-1:0]     x;
    logic [DIM_BITS-1:0]     y;
    logic                    done;
  } walk_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] n;
    n = -v;
    return v[VEC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  function automatic logic signed [VEC_W-1:0] sgn(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v[VEC_W-1]) begin
      r = -VEC_W'(1);
    end else if (v != '0) begin
      r = VEC_W'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/ghi_cell.sv
// one subdivision step of the curve walk with its state register
// depends on ghi_pkg
module ghi_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ghi_pkg::walk_t state_i,
  output logic           valid_o,
  output ghi_pkg::walk_t state_o
);

  logic valid_q;
  ghi_pkg::walk_t state_q, state_d;

  logic signed [ghi_pkg::VEC_W-1:0] dax, day, dbx, dby;
  logic signed [ghi_pkg::VEC_W-1:0] ax2, ay2, bx2, by2, bx2a, by2a, ax2a, ay2a;
  logic [ghi_pkg::MAG_W-1:0]        ww, hh, w2, h2;
  logic [ghi_pkg::AREA_W-1:0]       n_two, n1, n2, rem_w, rem1;
  logic [ghi_pkg::DIM_BITS-1:0]     rlo;

  always_comb begin
    state_d = state_i;
    dax  = ghi_pkg::sgn(state_i.ax);
    day  = ghi_pkg::sgn(state_i.ay);
    dbx  = ghi_pkg::sgn(state_i.bx);
    dby  = ghi_pkg::sgn(state_i.by);
    ww   = ghi_pkg::mag(state_i.ax + state_i.ay);
    hh   = ghi_pkg::mag(state_i.bx + state_i.by);
    ax2  = state_i.ax >>> 1;
    ay2  = state_i.ay >>> 1;
    bx2  = state_i.bx >>> 1;
    by2  = state_i.by >>> 1;
    w2   = ghi_pkg::mag(ax2 + ay2);
    h2   = ghi_pkg::mag(bx2 + by2);
    ax2a = ax2;
    ay2a = ay2;
    bx2a = bx2;
    by2a = by2;
    if (w2[0] && ww > ghi_pkg::MAG_W'(2)) begin
      ax2a = ax2 + dax;
      ay2a = ay2 + day;
    end
    if (h2[0] && hh > ghi_pkg::MAG_W'(2)) begin
      bx2a = bx2 + dbx;
      by2a = by2 + dby;
    end
    rlo   = state_i.rem[ghi_pkg::DIM_BITS-1:0];
    rem_w = ghi_pkg::AREA_W'(state_i.rem);
    n_two = ghi_pkg::mag(ax2a + ay2a) * hh;
    n1    = ghi_pkg::mag(bx2a + by2a) * ghi_pkg::mag(ax2 + ay2);
    rem1  = rem_w - n1;
    n2    = ww * ghi_pkg::mag((state_i.bx - bx2a) + (state_i.by - by2a));

    if (!state_i.done) begin
      if (hh == ghi_pkg::MAG_W'(1)) begin
        state_d.done = 1'b1;
        if (dax[ghi_pkg::VEC_W-1]) state_d.x = state_i.x - rlo;
        else if (dax != '0)        state_d.x = state_i.x + rlo;
        if (day[ghi_pkg::VEC_W-1]) state_d.y = state_i.y - rlo;
        else if (day != '0)        state_d.y = state_i.y + rlo;
      end else if (ww == ghi_pkg::MAG_W'(1)) begin
        state_d.done = 1'b1;
        if (dbx[ghi_pkg::VEC_W-1]) state_d.x = state_i.x - rlo;
        else if (dbx != '0)        state_d.x = state_i.x + rlo;
        if (dby[ghi_pkg::VEC_W-1]) state_d.y = state_i.y - rlo;
        else if (dby != '0)        state_d.y = state_i.y + rlo;
      end else if ({1'b0, ww, 1'b0} > ({2'b0, hh} + {1'b0, hh, 1'b0})) begin
        // split in two along the long side
        if (rem_w < n_two) begin
          state_d.ax = ax2a;
          state_d.ay = ay2a;
        end else begin
          state_d.rem = ghi_pkg::IDX_W'(rem_w - n_two);
          state_d.x   = state_i.x + ax2a[ghi_pkg::DIM_BITS-1:0];
          state_d.y   = state_i.y + ay2a[ghi_pkg::DIM_BITS-1:0];
          state_d.ax  = state_i.ax - ax2a;
          state_d.ay  = state_i.ay - ay2a;
        end
      end else if (rem_w < n1) begin
        state_d.ax = bx2a;
        state_d.ay = by2a;
        state_d.bx = ax2;
        state_d.by = ay2;
      end else if (rem1 < n2) begin
        state_d.rem = ghi_pkg::IDX_W'(rem1);
        state_d.x   = state_i.x + bx2a[ghi_pkg::DIM_BITS-1:0];
        state_d.y   = state_i.y + by2a[ghi_pkg::DIM_BITS-1:0];
        state_d.bx  = state_i.bx - bx2a;
        state_d.by  = state_i.by - by2a;
      end else begin
        state_d.rem = ghi_pkg::IDX_W'(rem1 - n2);
        state_d.x   = state_i.x + ghi_pkg::DIM_BITS'((state_i.ax - dax) + (bx2a - dbx));
        state_d.y   = state_i.y + ghi_pkg::DIM_BITS'((state_i.ay - day) + (by2a - dby));
        state_d.ax  = -bx2a;
        state_d.ay  = -by2a;
        state_d.bx  = ax2 - state_i.ax;
        state_d.by  = ay2 - state_i.ay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

FILE: hdl/generalized_hilbert_index_to_xy_core.sv
// generalized hilbert curve index to x,y converter, top level
// depends on ghi_pkg and ghi_cell
//
// One request is converted at a time. After a request is taken the index is
// checked against width*height in a check state, then the walk state circulates
// through a ring of four subdivision cells, one level per cell per cycle unless a
// finished walk is held waiting for the output register, until a strip one cell
// wide ends the walk, with up to about two levels per dimension bit. An out of
// range index ends in the check state without a walk. The next request is taken
// while the previous result waits in the output register.
module generalized_hilbert_index_to_xy_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ghi_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ghi_pkg::IDX_W-1:0]     s_axis_tdata,   // curve_index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*ghi_pkg::DIM_BITS-1:0] m_axis_tdata,  // x_coord, y_coord
  output logic                          m_axis_tuser    // index_valid
);

  ghi_pkg::state_e state_q, state_d;

  logic [ghi_pkg::REG_W-1:0]  width_q, height_q;
  logic [ghi_pkg::MAG_W-1:0]  wc, hc;
  logic [ghi_pkg::AREA_W-1:0] area_q;
  logic [ghi_pkg::IDX_W-1:0]  idx_q;

  logic                        out_vld_q;
  logic [ghi_pkg::DIM_BITS-1:0] out_x_q, out_y_q;
  logic                        out_ok_q;

  logic accept, in_range, out_ok, inject, drop, exit_w, en;
  logic feed_vld;
  ghi_pkg::walk_t feed, init;

  logic           cell_vld [ghi_pkg::N_CELLS];
  ghi_pkg::walk_t cell_st  [ghi_pkg::N_CELLS];
  logic [ghi_pkg::N_CELLS-1:0] vld_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ghi_pkg::REG_W'(16);
      height_q <= ghi_pkg::REG_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ghi_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        ghi_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wc = (width_q > ghi_pkg::REG_W'(ghi_pkg::DIM_MAX)) ? ghi_pkg::DIM_MAX
                                                           : width_q[ghi_pkg::MAG_W-1:0];
  assign hc = (height_q > ghi_pkg::REG_W'(ghi_pkg::DIM_MAX)) ? ghi_pkg::DIM_MAX
                                                            : height_q[ghi_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    area_q <= wc * hc;
    if (accept) begin
      idx_q <= s_axis_tdata;
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_range = ghi_pkg::AREA_W'(idx_q) < area_q;
  assign out_ok   = !out_vld_q || m_axis_tready;
  assign exit_w   = cell_vld[ghi_pkg::N_CELLS-1] && cell_st[ghi_pkg::N_CELLS-1].done && out_ok;
  assign en       = !(cell_vld[ghi_pkg::N_CELLS-1] && cell_st[ghi_pkg::N_CELLS-1].done
                      && !out_ok);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ghi_pkg::ST_IDLE:  if (accept) state_d = ghi_pkg::ST_CHECK;
      ghi_pkg::ST_CHECK: begin
        if (in_range)    state_d = ghi_pkg::ST_RUN;
        else if (out_ok) state_d = ghi_pkg::ST_IDLE;
      end
      ghi_pkg::ST_RUN:   if (exit_w) state_d = ghi_pkg::ST_IDLE;
      default:           state_d = ghi_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    inject        = 1'b0;
    drop          = 1'b0;
    unique case (state_q)
      ghi_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      ghi_pkg::ST_CHECK: begin
        inject = in_range;
        drop   = !in_range && out_ok;
      end
      ghi_pkg::ST_RUN:   ;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ghi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    init.rem  = idx_q;
    init.x    = '0;
    init.y    = '0;
    init.done = 1'b0;
    if (wc >= hc) begin
      init.ax = ghi_pkg::VEC_W'(wc);
      init.ay = '0;
      init.bx = '0;
      init.by = ghi_pkg::VEC_W'(hc);
    end else begin
      init.ax = '0;
      init.ay = ghi_pkg::VEC_W'(hc);
      init.bx = ghi_pkg::VEC_W'(wc);
      init.by = '0;
    end
  end

  assign feed     = inject ? init : cell_st[ghi_pkg::N_CELLS-1];
  assign feed_vld = inject || (cell_vld[ghi_pkg::N_CELLS-1]
                               && !cell_st[ghi_pkg::N_CELLS-1].done);

  for (genvar k = 0; k < ghi_pkg::N_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_first
      ghi_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (feed_vld),
        .state_i (feed),
        .valid_o (cell_vld[k]),
        .state_o (cell_st[k])
      );
    end else begin : g_next
      ghi_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (cell_vld[k-1]),
        .state_i (cell_st[k-1]),
        .valid_o (cell_vld[k]),
        .state_o (cell_st[k])
      );
    end
    assign vld_vec[k] = cell_vld[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_ok_q  <= 1'b0;
    end else if (exit_w || drop) begin
      out_vld_q <= 1'b1;
      out_ok_q  <= exit_w;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_w) begin
      out_x_q <= cell_st[ghi_pkg::N_CELLS-1].x;
      out_y_q <= cell_st[ghi_pkg::N_CELLS-1].y;
    end else if (drop) begin
      out_x_q <= '0;
      out_y_q <= '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_ok_q;

`ifndef SYNTHESIS
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) <= 1)
    else $error("more than one walk in the cell ring");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (vld_vec == '0))
    else $error("request taken while a walk is active");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out of range result with nonzero coordinates");
`endif

endmodule

FILE: dv/tb_generalized_hilbert_index_to_xy_core.sv
// testbench for generalized_hilbert_index_to_xy_core: directed and random index requests
// over many rectangle sizes, each result checked against a gilbert curve walk in the bench
// depends on ghi_pkg and the core rtl
module tb_generalized_hilbert_index_to_xy_core;

  typedef struct {
    logic [ghi_pkg::DIM_BITS-1:0] x;
    logic [ghi_pkg::DIM_BITS-1:0] y;
    logic                         valid;
  } cell_xy_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic                            cfg_idx_i;
  logic [ghi_pkg::REG_W-1:0]       cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [ghi_pkg::IDX_W-1:0]       s_axis_tdata;   // curve_index
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [2*ghi_pkg::DIM_BITS-1:0]  m_axis_tdata;   // x_coord, y_coord
  logic                            m_axis_tuser;   // index_valid

  logic [ghi_pkg::REG_W-1:0] rect_width;
  logic [ghi_pkg::REG_W-1:0] rect_height;
  cell_xy_t         pending_xy[$];
  int               err_cnt;
  int               cycle_cnt;
  bit               tx_idle_en;
  bit               rx_idle_en;
  bit               rx_hold_req;

  generalized_hilbert_index_to_xy_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint sgn_l(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint half_l(input longint v);
    return (v >= 0) ? v / 2 : -((-v + 1) / 2);
  endfunction

  // gilbert walk, one subdivision level per pass
  function automatic cell_xy_t walk_to_xy(input logic [ghi_pkg::IDX_W-1:0] idx);
    cell_xy_t r;
    longint w, h, ax, ay, bx, by, x, y, cur, dst;
    longint ww, hh, dax, day, dbx, dby, di, ax2, ay2, bx2, by2, w2, h2, nxt, t0, t1;
    r.x = '0;
    r.y = '0;
    r.valid = 1'b0;
    w = (rect_width > 4096) ? 4096 : rect_width;
    h = (rect_height > 4096) ? 4096 : rect_height;
    dst = idx;
    if (w == 0 || h == 0 || dst >= w * h) return r;
    x = 0; y = 0; cur = 0;
    if (w >= h) begin
      ax = w; ay = 0; bx = 0; by = h;
    end else begin
      ax = 0; ay = h; bx = w; by = 0;
    end
    for (int g = 0; g < 1024; g++) begin
      ww = abs_l(ax + ay); hh = abs_l(bx + by);
      dax = sgn_l(ax); day = sgn_l(ay); dbx = sgn_l(bx); dby = sgn_l(by);
      di = dst - cur;
      if (hh == 1) begin
        x += dax * di; y += day * di;
        break;
      end
      if (ww == 1) begin
        x += dbx * di; y += dby * di;
        break;
      end
      ax2 = half_l(ax); ay2 = half_l(ay); bx2 = half_l(bx); by2 = half_l(by);
      w2 = abs_l(ax2 + ay2); h2 = abs_l(bx2 + by2);
      if (2 * ww > 3 * hh) begin
        if ((w2 & 1) != 0 && ww > 2) begin
          ax2 += dax; ay2 += day;
        end
        nxt = cur + abs_l((ax2 + ay2) * (bx + by));
        if (cur <= dst && dst < nxt) begin
          ax = ax2; ay = ay2;
        end else begin
          cur = nxt;
          x += ax2; y += ay2;
          ax -= ax2; ay -= ay2;
        end
      end else begin
        if ((h2 & 1) != 0 && hh > 2) begin
          bx2 += dbx; by2 += dby;
        end
        nxt = cur + abs_l((bx2 + by2) * (ax2 + ay2));
        if (cur <= dst && dst < nxt) begin
          ax = bx2; ay = by2; bx = ax2; by = ay2;
        end else begin
          cur = nxt;
          nxt = cur + abs_l((ax + ay) * ((bx - bx2) + (by - by2)));
          if (cur <= dst && dst < nxt) begin
            x += bx2; y += by2;
            bx -= bx2; by -= by2;
          end else begin
            cur = nxt;
            x += (ax - dax) + (bx2 - dbx);
            y += (ay - day) + (by2 - dby);
            t0 = -(ax - ax2);
            t1 = -(ay - ay2);
            ax = -bx2; ay = -by2;
            bx = t0; by = t1;
          end
        end
      end
    end
    r.x = x[ghi_pkg::DIM_BITS-1:0];
    r.y = y[ghi_pkg::DIM_BITS-1:0];
    r.valid = 1'b1;
    return r;
  endfunction

  // one request, held until taken
  task automatic send_index(input logic [ghi_pkg::IDX_W-1:0] idx);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_xy.push_back(walk_to_xy(idx));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_xy.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_rect(input logic [ghi_pkg::REG_W-1:0] w,
                          input logic [ghi_pkg::REG_W-1:0] h);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ghi_pkg::REG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= ghi_pkg::REG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    rect_width  = w;
    rect_height = h;
    @(posedge clk_i);
  endtask

  function automatic logic [ghi_pkg::IDX_W-1:0] pick_index();
    int unsigned area;
    int unsigned w, h;
    w = (rect_width > 4096) ? 4096 : rect_width;
    h = (rect_height > 4096) ? 4096 : rect_height;
    area = w * h;
    if (area > 0 && $urandom_range(0, 7) != 0) begin
      return ghi_pkg::IDX_W'($urandom_range(0, area - 1));
    end
    if (area > 0 && area < 24'hFFFFFF && $urandom_range(0, 1) == 0) begin
      return ghi_pkg::IDX_W'(area);
    end
    return ghi_pkg::IDX_W'($urandom);
  endfunction

  task automatic test_reset_size();
    send_index('0);
    send_index(ghi_pkg::IDX_W'(255));
    send_index(ghi_pkg::IDX_W'(256));
    send_index('1);
  endtask

  task automatic test_size_extremes();
    set_rect(13'd1, 13'd1);
    send_index('0);
    send_index(ghi_pkg::IDX_W'(1));
    set_rect(13'd0, 13'd5);
    send_index('0);
    set_rect(13'd6, 13'd0);
    send_index('0);
    set_rect(13'd4096, 13'd4096);
    send_index('0);
    send_index('1);
    send_index(ghi_pkg::IDX_W'(24'hAAAAAA));
    send_index(ghi_pkg::IDX_W'(24'h555555));
    set_rect(13'h1FFF, 13'd4097);
    send_index('1);
    send_index(ghi_pkg::IDX_W'(12345));
    set_rect(13'd4096, 13'd1);
    send_index(ghi_pkg::IDX_W'(4095));
    send_index(ghi_pkg::IDX_W'(4096));
    set_rect(13'd1, 13'd4096);
    send_index(ghi_pkg::IDX_W'(2000));
    set_rect(13'd7, 13'd3);
    send_index(ghi_pkg::IDX_W'(11));
    send_index(ghi_pkg::IDX_W'(20));
    set_rect(13'd100, 13'd3);
    send_index(ghi_pkg::IDX_W'(150));
    send_index(ghi_pkg::IDX_W'(299));
  endtask

  task automatic test_random_sizes(input int phases, input int per_phase);
    logic [ghi_pkg::REG_W-1:0] w, h;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0: begin
          w = ghi_pkg::REG_W'($urandom_range(1, 4096));
          h = ghi_pkg::REG_W'($urandom_range(1, 4096));
        end
        1: begin
          w = ghi_pkg::REG_W'($urandom);
          h = ghi_pkg::REG_W'($urandom_range(0, 3));
        end
        2: begin
          w = ghi_pkg::REG_W'($urandom_range(1, 8));
          h = ghi_pkg::REG_W'($urandom_range(200, 4096));
        end
        default: begin
          w = ghi_pkg::REG_W'($urandom_range(1, 64));
          h = ghi_pkg::REG_W'($urandom_range(1, 64));
        end
      endcase
      set_rect(w, h);
      for (int i = 0; i < per_phase; i++) send_index(pick_index());
    end
  endtask

  task automatic test_output_stall();
    set_rect(13'd33, 13'd20);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_index(pick_index());
  endtask

  task automatic test_no_idle();
    drain_results();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_sizes(4, 50);
  endtask

  // result side readiness: bursts of stall, plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_xy.size() == 0) begin
        $error("unexpected result x=%0d y=%0d valid=%0b",
               m_axis_tdata[ghi_pkg::DIM_BITS-1:0],
               m_axis_tdata[2*ghi_pkg::DIM_BITS-1:ghi_pkg::DIM_BITS], m_axis_tuser);
        err_cnt++;
      end else begin
        automatic cell_xy_t e = pending_xy.pop_front();
        if (m_axis_tdata[ghi_pkg::DIM_BITS-1:0] !== e.x) begin
          $error("x_coord expected %0d actual %0d", e.x,
                 m_axis_tdata[ghi_pkg::DIM_BITS-1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[2*ghi_pkg::DIM_BITS-1:ghi_pkg::DIM_BITS] !== e.y) begin
          $error("y_coord expected %0d actual %0d", e.y,
                 m_axis_tdata[2*ghi_pkg::DIM_BITS-1:ghi_pkg::DIM_BITS]);
          err_cnt++;
        end
        if (m_axis_tuser !== e.valid) begin
          $error("index_valid expected %0b actual %0b", e.valid, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    err_cnt       = 0;
    cycle_cnt     = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_req   = 1'b0;
    rect_width    = 13'd16;
    rect_height   = 13'd16;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ghi_pkg::REG_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_size_extremes();
    test_random_sizes(21, 60);
    test_output_stall();
    test_no_idle();

    drain_results();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: generalized_hilbert_index_to_xy_core.f
hdl/ghi_pkg.sv
hdl/ghi_cell.sv
hdl/generalized_hilbert_index_to_xy_core.sv
dv/tb_generalized_hilbert_index_to_xy_core.sv
